// ----- hw/rtl/olpi_pkg.sv -----
package olpi_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;
  localparam int KIND_W   = 3;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_INSERT_AT  = 3'd4,
    KIND_DELETE_AT  = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  // Broadcast to every cell of the chain in the cycle a transfer is taken.
  typedef struct packed {
    cell_op_t           op;
    logic [CNT_W-1:0]   at;
    logic [VAL_W-1:0]   value;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/ordered_list_position_insert_delete_core.sv -----
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_tvalid / in_tready   | kind, value, position
// out_    | output    | out_tvalid / out_tready | status, length, first_value, last_value
//
// For every list operation, all cells of the chain shift in
// parallel at the edge the input transfer is taken, and the result is valid the
// next cycle. One item per cycle is sustained while out_tready stays high.
// A stalled result holds the list; no new input is taken until it is transferred.
// rst_n (synchronous) empties the list; cell contents are not cleared.
module ordered_list_position_insert_delete_core
  import olpi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // kind[2:0], value[34:3], position[39:35]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // status[1:0], length[6:2], first_value[38:7],
                                            // last_value[70:39], zero[71]
);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  status_t           status_r;
  status_t           status;
  cell_ctl_t         dec_ctl;
  cell_ctl_t         ctl;
  logic              in_xfer;
  logic [VAL_W-1:0]  cell_val [CAPACITY];
  logic [VAL_W-1:0]  first_value;
  logic [VAL_W-1:0]  last_value;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  olpi_ctrl u_ctrl (
    .kind      (in_tdata[2:0]),
    .value     (in_tdata[34:3]),
    .position  (in_tdata[39:35]),
    .count     (count_r),
    .status    (status),
    .ctl       (dec_ctl),
    .count_nxt (count_nxt)
  );

  always_comb begin
    ctl = dec_ctl;
    if (!in_xfer) begin
      ctl.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;
    if (i == 0) begin : g_head
      assign left_val = '0;
    end else begin : g_left
      assign left_val = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_right
      assign right_val = cell_val[i+1];
    end
    olpi_cell u_cell (
      .clk       (clk),
      .idx       (CNT_W'(i)),
      .ctl       (ctl),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r <= count_nxt;
      end
      if (in_tready) begin
        out_valid_r <= in_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r <= status;
    end
  end

  // The list cannot change while a result waits, so first and last values are
  // taken straight from the cells.
  always_comb begin
    first_value = (count_r == '0) ? '0 : cell_val[0];
    last_value  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (count_r == CNT_W'(i + 1)) begin
        last_value = cell_val[i];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, last_value, first_value, LEN_W'(count_r), status_r};

endmodule

// ----- hw/rtl/olpi_cell.sv -----
module olpi_cell
  import olpi_pkg::*;
(
  input  logic             clk,
  input  logic [CNT_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  logic [VAL_W-1:0] left_val,
  input  logic [VAL_W-1:0] right_val,
  output logic [VAL_W-1:0] val
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      CELL_INSERT: begin
        // Cells past the hole take their left neighbor; the hole takes the new value.
        if (idx == ctl.at) begin
          val_nxt = ctl.value;
        end else if (idx > ctl.at) begin
          val_nxt = left_val;
        end
      end
      CELL_DELETE: begin
        if (idx >= ctl.at) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ----- hw/rtl/olpi_ctrl.sv -----
module olpi_ctrl
  import olpi_pkg::*;
(
  input  logic [KIND_W-1:0] kind,
  input  logic [VAL_W-1:0]  value,
  input  logic [POS_W-1:0]  position,
  input  logic [CNT_W-1:0]  count,
  output status_t           status,
  output cell_ctl_t         ctl,
  output logic [CNT_W-1:0]  count_nxt
);

  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;

  assign full  = (count == CNT_W'(CAPACITY));
  assign empty = (count == '0);
  assign pos_c = CMP_W'(position);
  assign cnt_c = CMP_W'(count);

  always_comb begin
    status    = STAT_OK;
    ctl.op    = CELL_HOLD;
    ctl.at    = '0;
    ctl.value = value;
    count_nxt = count;
    unique case (kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT_AT: begin
        if (full) begin
          status = STAT_FULL;
        end else if (kind == KIND_INSERT_AT && pos_c > cnt_c) begin
          status = STAT_BADPOS;
        end else begin
          ctl.op    = CELL_INSERT;
          ctl.at    = (kind == KIND_PUSH_FRONT) ? '0 :
                      (kind == KIND_PUSH_BACK)  ? count : CNT_W'(position);
          count_nxt = count + CNT_W'(1);
        end
      end
      KIND_POP_FRONT, KIND_POP_BACK, KIND_DELETE_AT: begin
        if (empty) begin
          status = STAT_EMPTY;
        end else if (kind == KIND_DELETE_AT && pos_c >= cnt_c) begin
          status = STAT_BADPOS;
        end else begin
          ctl.op    = CELL_DELETE;
          ctl.at    = (kind == KIND_POP_FRONT) ? '0 :
                      (kind == KIND_POP_BACK)  ? count - CNT_W'(1) : CNT_W'(position);
          count_nxt = count - CNT_W'(1);
        end
      end
      default: status = STAT_OK;
    endcase
  end

endmodule
